>>> rtl/ssvu_pkg.sv
// ssvu_pkg: shared types, constants and color functions for the stereo vu bar renderer
// no dependencies; imported by ssvu_lane, ssvu_merge and the top level
`default_nettype none

package ssvu_pkg;

  localparam int LEVEL_W = 16;
  localparam int CNT_W   = 6;
  localparam int COL_W   = 6;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_SMOOTHING  = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_MODE = 2'd1;
  localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

  // color schemes; the unused code falls back to solid green
  localparam logic [1:0] MODE_RAINBOW = 2'd0;
  localparam logic [1:0] MODE_HEAT    = 2'd1;
  localparam logic [1:0] MODE_GREEN   = 2'd2;

  localparam logic [7:0] BRIGHT_FULL = 8'd255;

  // smoothing lane status toward the column merge stage
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] avg;
  } lane_stat_t;

  // heat gradient per column, {red, green, blue}
  localparam logic [23:0] HEAT_LUT [0:31] = '{
    24'h000040, 24'h0C0046, 24'h18004C, 24'h240052,
    24'h300058, 24'h3C005E, 24'h480064, 24'h54006A,
    24'h600070, 24'h6D0076, 24'h79007C, 24'h85007A,
    24'h91006E, 24'h9D0062, 24'hA90056, 24'hB5004A,
    24'hC1003E, 24'hCD0031, 24'hD90025, 24'hE50019,
    24'hF1000D, 24'hFD0001, 24'hFF1000, 24'hFF2200,
    24'hFF3400, 24'hFF4700, 24'hFF5900, 24'hFF6C00,
    24'hFF7E00, 24'hFF9000, 24'hFFA300, 24'hFFB500
  };

  // hsv rainbow, hue in sixteenths of a 60 degree sector, 3 per column
  function automatic logic [23:0] rainbow_rgb(input logic [4:0] c);
    logic [6:0]  h;
    logic [2:0]  sector;
    logic [4:0]  f;
    logic [4:0]  x16;
    logic [12:0] prod;
    logic [7:0]  x;
    h      = 7'(c) * 7'd3;
    sector = h[6:4];
    f      = h[4:0];
    x16    = (f >= 5'd16) ? 5'(6'd32 - 6'(f)) : f;
    prod   = 13'(x16) * 13'd255;
    x      = prod[11:4];
    case (sector)
      3'd0:    rainbow_rgb = {8'd255, x, 8'd0};
      3'd1:    rainbow_rgb = {x, 8'd255, 8'd0};
      3'd2:    rainbow_rgb = {8'd0, 8'd255, x};
      3'd3:    rainbow_rgb = {8'd0, x, 8'd255};
      3'd4:    rainbow_rgb = {x, 8'd0, 8'd255};
      default: rainbow_rgb = {8'd255, 8'd0, x};
    endcase
  endfunction

  // ch * br / 255 truncated, exact for 8 by 8 bit products
  function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] ch,
                                               input logic [CH_W-1:0] br);
    logic [15:0] p;
    logic [16:0] q;
    p        = 16'(ch) * 16'(br);
    q        = 17'(p) + 17'(p[15:8]) + 17'd1;
    scale_ch = q[15:8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/ssvu_lane.sv
// ssvu_lane: one smoothing lane, exponential average of one side's loudness
// depends on ssvu_pkg
`default_nettype none

module ssvu_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ssvu_pkg::LEVEL_W-1:0] level,
  input  logic [ssvu_pkg::LEVEL_W-1:0] smoothing,
  output ssvu_pkg::lane_stat_t         stat
);
  import ssvu_pkg::*;

  logic [31:0]        prod_old_r, prod_old_nxt;
  logic [31:0]        prod_new_r, prod_new_nxt;
  logic [32:0]        prod_new_full;
  logic [16:0]        weight_new;
  logic [32:0]        sum;
  logic               p1_vld_r, p1_vld_nxt;
  logic               done_r, done_nxt;
  logic [LEVEL_W-1:0] avg_r, avg_nxt;

  // stage one: weight old average and new level
  always_comb begin
    weight_new    = 17'd65536 - 17'(smoothing);
    prod_new_full = 33'(level) * 33'(weight_new);
    prod_old_nxt  = start ? 32'(avg_r) * 32'(smoothing) : prod_old_r;
    prod_new_nxt  = start ? prod_new_full[31:0] : prod_new_r;
    p1_vld_nxt    = start;
  end

  // stage two: sum and keep the upper half as the new average
  always_comb begin
    sum      = 33'(prod_old_r) + 33'(prod_new_r);
    avg_nxt  = p1_vld_r ? sum[31:16] : avg_r;
    done_nxt = p1_vld_r;
  end

  always_ff @(posedge clk) begin
    prod_old_r <= prod_old_nxt;
    prod_new_r <= prod_new_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      done_r   <= 1'b0;
      avg_r    <= '0;
    end else begin
      p1_vld_r <= p1_vld_nxt;
      done_r   <= done_nxt;
      avg_r    <= avg_nxt;
    end
  end

  assign stat.busy = p1_vld_r | done_r;
  assign stat.done = done_r;
  assign stat.avg  = avg_r;

endmodule

`default_nettype wire

>>> rtl/ssvu_merge.sv
// ssvu_merge: merges both lanes into lit counts and walks the columns, one result a cycle
// while out_ready is high; depends on ssvu_pkg; fed by two ssvu_lane instances
`default_nettype none

module ssvu_merge #(
  parameter int COLS_PER_SIDE = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssvu_pkg::lane_stat_t         lane_l,
  input  ssvu_pkg::lane_stat_t         lane_r,
  input  logic [1:0]                   color_mode,
  input  logic [ssvu_pkg::CH_W-1:0]    brightness,
  output logic                         pend_busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ssvu_pkg::COL_W-1:0]   out_column,
  output logic [ssvu_pkg::CH_W-1:0]    out_red,
  output logic [ssvu_pkg::CH_W-1:0]    out_green,
  output logic [ssvu_pkg::CH_W-1:0]    out_blue,
  output logic                         out_final_column
);
  import ssvu_pkg::*;

  localparam int CW     = $clog2(2 * COLS_PER_SIDE);
  localparam int SIDE_W = (COLS_PER_SIDE > 1) ? $clog2(COLS_PER_SIDE) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(2 * COLS_PER_SIDE - 1);
  localparam logic [CW-1:0] SIDE_COLS = CW'(COLS_PER_SIDE);

  logic [21:0]      lprod, rprod;
  logic             pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0] pend_l_r, pend_l_nxt, pend_r_r, pend_r_nxt;
  logic             act_r, act_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt, rcnt_r, rcnt_nxt;
  logic             adv, emit, last, take;
  logic             is_right, lit;
  logic [CW-1:0]    c_full;
  logic [SIDE_W-1:0] c;
  logic [CNT_W-1:0] side_cnt;
  logic [23:0]      base_rgb, rgb;
  logic             out_vld_r, out_vld_nxt;
  logic [COL_W-1:0] col_out_r, col_out_nxt;
  logic [CH_W-1:0]  red_r, red_nxt, grn_r, grn_nxt, blu_r, blu_nxt;
  logic             fin_r, fin_nxt;

  // lit counts from the fresh averages, held until the column walk is free
  always_comb begin
    lprod = 22'(lane_l.avg) * 22'(COLS_PER_SIDE);
    rprod = 22'(lane_r.avg) * 22'(COLS_PER_SIDE);
  end

  // column walk control
  always_comb begin
    adv  = !out_vld_r || out_ready;
    emit = act_r && adv;
    last = (col_r == LAST_COL);
    take = pend_vld_r && (!act_r || (emit && last));

    pend_vld_nxt = pend_vld_r;
    pend_l_nxt   = pend_l_r;
    pend_r_nxt   = pend_r_r;
    if (take) begin
      pend_vld_nxt = 1'b0;
    end
    if (lane_l.done && lane_r.done) begin
      pend_vld_nxt = 1'b1;
      pend_l_nxt   = lprod[21:16];
      pend_r_nxt   = rprod[21:16];
    end

    act_nxt  = act_r;
    col_nxt  = col_r;
    lcnt_nxt = lcnt_r;
    rcnt_nxt = rcnt_r;
    if (emit) begin
      col_nxt = col_r + CW'(1);
      if (last) begin
        act_nxt = 1'b0;
      end
    end
    if (take) begin
      act_nxt  = 1'b1;
      col_nxt  = '0;
      lcnt_nxt = pend_l_r;
      rcnt_nxt = pend_r_r;
    end
  end

  // color of the current column
  always_comb begin
    is_right = (col_r >= SIDE_COLS);
    c_full   = is_right ? col_r - SIDE_COLS : col_r;
    c        = c_full[SIDE_W-1:0];
    side_cnt = is_right ? rcnt_r : lcnt_r;
    lit      = (CNT_W'(c) < side_cnt);
    case (color_mode)
      MODE_RAINBOW: base_rgb = rainbow_rgb(5'(c));
      MODE_HEAT:    base_rgb = HEAT_LUT[5'(c)];
      MODE_GREEN:   base_rgb = {8'd0, 8'd255, 8'd0};
      default:      base_rgb = {8'd0, 8'd255, 8'd0};
    endcase
    rgb = lit ? {scale_ch(base_rgb[23:16], brightness),
                 scale_ch(base_rgb[15:8], brightness),
                 scale_ch(base_rgb[7:0], brightness)} : 24'd0;
  end

  // output register, loads on every free slot
  always_comb begin
    out_vld_nxt = out_vld_r;
    col_out_nxt = col_out_r;
    red_nxt     = red_r;
    grn_nxt     = grn_r;
    blu_nxt     = blu_r;
    fin_nxt     = fin_r;
    if (adv) begin
      out_vld_nxt = emit;
    end
    if (emit) begin
      col_out_nxt = COL_W'(col_r);
      red_nxt     = rgb[23:16];
      grn_nxt     = rgb[15:8];
      blu_nxt     = rgb[7:0];
      fin_nxt     = last;
    end
  end

  always_ff @(posedge clk) begin
    pend_l_r  <= pend_l_nxt;
    pend_r_r  <= pend_r_nxt;
    lcnt_r    <= lcnt_nxt;
    rcnt_r    <= rcnt_nxt;
    col_out_r <= col_out_nxt;
    red_r     <= red_nxt;
    grn_r     <= grn_nxt;
    blu_r     <= blu_nxt;
    fin_r     <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      act_r      <= 1'b0;
      col_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      act_r      <= act_nxt;
      col_r      <= col_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign pend_busy        = pend_vld_r;
  assign out_valid        = out_vld_r;
  assign out_column       = col_out_r;
  assign out_red          = red_r;
  assign out_green        = grn_r;
  assign out_blue         = blu_r;
  assign out_final_column = fin_r;

endmodule

`default_nettype wire

>>> rtl/smoothed_stereo_vu_bar_render_top.sv
// smoothed_stereo_vu_bar_render_top: config registers, two smoothing lanes, column merge
// depends on ssvu_pkg, ssvu_lane and ssvu_merge
//
//   port group | direction | transfer condition
//   in_*       | input     | in_valid & in_ready, left and right loudness
//   out_*      | output    | out_valid & out_ready, one column color per transfer
//   cfg_*      | input     | cfg_wr_en high, no wait, no read-back
//
// each item yields 2*COLS_PER_SIDE results (64 at the default), one per cycle
// while out_ready is high; the column walk in ssvu_merge sets that rate.
// a result passes both lane stages, the pending slot, column walk and output register;
// the next item is taken while the current one is walked and waits in a pending slot.
// reset clears both averages and loads smoothing 0, solid green, brightness 255.
`default_nettype none

module smoothed_stereo_vu_bar_render_top #(
  parameter int COLS_PER_SIDE = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ssvu_pkg::LEVEL_W-1:0] in_left_level,
  input  logic [ssvu_pkg::LEVEL_W-1:0] in_right_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ssvu_pkg::COL_W-1:0]  out_column,
  output logic [ssvu_pkg::CH_W-1:0]   out_red,
  output logic [ssvu_pkg::CH_W-1:0]   out_green,
  output logic [ssvu_pkg::CH_W-1:0]   out_blue,
  output logic                        out_final_column,
  input  logic                        cfg_wr_en,
  input  logic [ssvu_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ssvu_pkg::LEVEL_W-1:0] cfg_wdata
);
  import ssvu_pkg::*;

  logic [LEVEL_W-1:0] smoothing_r, smoothing_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [CH_W-1:0]    bright_r, bright_nxt;
  lane_stat_t         lstat, rstat;
  logic               pend_busy;
  logic               in_xfer;

  // configuration writes, unknown indexes ignored
  always_comb begin
    smoothing_nxt = smoothing_r;
    mode_nxt      = mode_r;
    bright_nxt    = bright_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SMOOTHING:  smoothing_nxt = cfg_wdata;
        REG_COLOR_MODE: mode_nxt      = cfg_wdata[1:0];
        REG_BRIGHTNESS: bright_nxt    = cfg_wdata[CH_W-1:0];
        default:        smoothing_nxt = smoothing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_r <= '0;
      mode_r      <= MODE_GREEN;
      bright_r    <= BRIGHT_FULL;
    end else begin
      smoothing_r <= smoothing_nxt;
      mode_r      <= mode_nxt;
      bright_r    <= bright_nxt;
    end
  end

  // one item in the lanes or the pending slot at a time
  assign in_ready = !lstat.busy && !rstat.busy && !pend_busy;
  assign in_xfer  = in_valid && in_ready;

  ssvu_lane u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .level     (in_left_level),
    .smoothing (smoothing_r),
    .stat      (lstat)
  );

  ssvu_lane u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .level     (in_right_level),
    .smoothing (smoothing_r),
    .stat      (rstat)
  );

  ssvu_merge #(
    .COLS_PER_SIDE (COLS_PER_SIDE)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .lane_l           (lstat),
    .lane_r           (rstat),
    .color_mode       (mode_r),
    .brightness       (bright_r),
    .pend_busy        (pend_busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_final_column (out_final_column)
  );

endmodule

`default_nettype wire

>>> rtl/ssvu_checker.sv
// ssvu_checker: port-level assertions on the result channel, bound to the top level
// depends on smoothed_stereo_vu_bar_render_top
`default_nettype none

module ssvu_checker #(
  parameter int COLS_PER_SIDE = 32
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_column,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_final_column
);

  localparam logic [5:0] LAST_COL = 6'(2 * COLS_PER_SIDE - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_final_column))
    else $error("stalled result changed");

  // the final flag marks exactly the last column
  a_final_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_column == (out_column == LAST_COL)))
    else $error("final flag and column disagree");

  // columns of a frame follow back to back
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_column |=>
      out_valid && (out_column == 6'($past(out_column) + 6'd1)))
    else $error("column sequence broken");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind smoothed_stereo_vu_bar_render_top ssvu_checker #(
  .COLS_PER_SIDE (COLS_PER_SIDE)
) u_ssvu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_column       (out_column),
  .out_red          (out_red),
  .out_green        (out_green),
  .out_blue         (out_blue),
  .out_final_column (out_final_column)
);

`default_nettype wire
